// File: hdl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants of the turret forward pose pipeline
// Angle and trig formats, series divisors with reciprocals, and the
// beat structs passed between the series cells and the back end.
// ----------------------------------------------------------------------------
package tfp_pkg;

	// number formats
	localparam int ANGLE_BITS     = 16;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
	localparam int LEN_W          = 17;
	localparam int POS_W          = 19;

	// series arithmetic widths (radians in Q30)
	localparam int X_W    = 31;
	localparam int X2_W   = 32;
	localparam int TERM_W = 34;
	localparam int ACC_W  = 36;
	localparam int DIV_W  = 8;
	localparam int RCP_SH = 34;
	localparam int RCP_W  = 34;

	localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
	localparam logic [X_W-1:0] ONE_Q30 = X_W'(1) << 30;

	// series cells: one cosine term per cell, and one sine term in all but the last
	localparam int CELLS    = 7;
	localparam int CELL_LAT = 4;
	localparam int SER_LAT  = CELLS * CELL_LAT;

	localparam logic [DIV_W-1:0] DIV_S [CELLS] = '{
		8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
	};
	localparam logic [DIV_W-1:0] DIV_C [CELLS] = '{
		8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182
	};
	localparam logic [RCP_W-1:0] RCP_S [CELLS] = '{
		RCP_W'((64'd1 << RCP_SH) / 6),   RCP_W'((64'd1 << RCP_SH) / 20),
		RCP_W'((64'd1 << RCP_SH) / 42),  RCP_W'((64'd1 << RCP_SH) / 72),
		RCP_W'((64'd1 << RCP_SH) / 110), RCP_W'((64'd1 << RCP_SH) / 156),
		RCP_W'((64'd1 << RCP_SH) / 210)
	};
	localparam logic [RCP_W-1:0] RCP_C [CELLS] = '{
		RCP_W'((64'd1 << RCP_SH) / 2),   RCP_W'((64'd1 << RCP_SH) / 12),
		RCP_W'((64'd1 << RCP_SH) / 30),  RCP_W'((64'd1 << RCP_SH) / 56),
		RCP_W'((64'd1 << RCP_SH) / 90),  RCP_W'((64'd1 << RCP_SH) / 132),
		RCP_W'((64'd1 << RCP_SH) / 182)
	};
	// cells add six sine terms and seven cosine terms
	localparam logic SIN_USE [CELLS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

	// register indexes
	typedef enum logic [1:0] {
		REG_LINK_OFFSET = 2'd0,
		REG_BASE_HEIGHT = 2'd1
	} reg_idx_t;

	// beat moving along the series cells
	typedef struct packed {
		logic                     valid;
		logic [X2_W-1:0]          x2;
		logic [TERM_W-1:0]        term_s;
		logic [TERM_W-1:0]        term_c;
		logic signed [ACC_W-1:0]  acc_s;
		logic signed [ACC_W-1:0]  acc_c;
	} ser_t;

	// side data riding beside the series
	typedef struct packed {
		logic [1:0]              quad_p;
		logic [1:0]              quad_t;
		logic signed [LEN_W-1:0] len;
	} side_t;

endpackage

// File: hdl/tfp_cell.sv
// ----------------------------------------------------------------------------
// tfp_cell: one Taylor term step for sine and cosine
// Multiplies the previous term by x^2, divides by a constant through a
// reciprocal with one correction step, and adds or subtracts into the sums.
// ----------------------------------------------------------------------------
module tfp_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  tfp_pkg::ser_t                 din,
	input  logic [tfp_pkg::DIV_W-1:0]     div_s,
	input  logic [tfp_pkg::RCP_W-1:0]     rcp_s,
	input  logic [tfp_pkg::DIV_W-1:0]     div_c,
	input  logic [tfp_pkg::RCP_W-1:0]     rcp_c,
	input  logic                          use_s,
	input  logic                          sub,
	output tfp_pkg::ser_t                 dout
);
	import tfp_pkg::*;

	logic [TERM_W+X2_W-1:0] prod_s, prod_c;
	logic [2*RCP_W-1:0]     rprod_s, rprod_c;
	logic [TERM_W+DIV_W-1:0] back_s, back_c;
	logic [TERM_W-1:0]      rem_s, rem_c;
	logic                   corr_s, corr_c;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [X2_W-1:0] x2_s1, x2_s2, x2_s3, x2_s4;
	logic signed [ACC_W-1:0] as_s1, as_s2, as_s3, as_s4;
	logic signed [ACC_W-1:0] ac_s1, ac_s2, ac_s3, ac_s4;
	logic [TERM_W-1:0] ps_s1, pc_s1, ps_s2, pc_s2;
	logic [TERM_W-1:0] qs_s2, qc_s2, qs_s3, qc_s3, qs_s4, qc_s4;
	logic [TERM_W-1:0] rs_s3, rc_s3;

	// term times x^2, then reciprocal multiply, then remainder check
	assign prod_s  = din.term_s * din.x2;
	assign prod_c  = din.term_c * din.x2;
	assign rprod_s = ps_s1 * rcp_s;
	assign rprod_c = pc_s1 * rcp_c;
	assign back_s  = qs_s2 * div_s;
	assign back_c  = qc_s2 * div_c;
	assign rem_s   = ps_s2 - back_s[TERM_W-1:0];
	assign rem_c   = pc_s2 - back_c[TERM_W-1:0];
	assign corr_s  = rem_s >= TERM_W'(div_s);
	assign corr_c  = rem_c >= TERM_W'(div_c);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= din.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			ps_s1 <= prod_s[TERM_W+29:30];
			pc_s1 <= prod_c[TERM_W+29:30];
			x2_s1 <= din.x2;
			as_s1 <= din.acc_s;
			ac_s1 <= din.acc_c;

			qs_s2 <= rprod_s[2*RCP_W-1:RCP_SH];
			qc_s2 <= rprod_c[2*RCP_W-1:RCP_SH];
			ps_s2 <= ps_s1;
			pc_s2 <= pc_s1;
			x2_s2 <= x2_s1;
			as_s2 <= as_s1;
			ac_s2 <= ac_s1;

			qs_s3 <= qs_s2 + TERM_W'(corr_s);
			qc_s3 <= qc_s2 + TERM_W'(corr_c);
			rs_s3 <= corr_s ? rem_s - TERM_W'(div_s) : rem_s;
			rc_s3 <= corr_c ? rem_c - TERM_W'(div_c) : rem_c;
			x2_s3 <= x2_s2;
			as_s3 <= as_s2;
			ac_s3 <= ac_s2;

			qs_s4 <= qs_s3;
			qc_s4 <= qc_s3;
			x2_s4 <= x2_s3;
			if (!use_s)
				as_s4 <= as_s3;
			else if (sub)
				as_s4 <= as_s3 - ACC_W'(signed'({1'b0, qs_s3}));
			else
				as_s4 <= as_s3 + ACC_W'(signed'({1'b0, qs_s3}));
			if (sub)
				ac_s4 <= ac_s3 - ACC_W'(signed'({1'b0, qc_s3}));
			else
				ac_s4 <= ac_s3 + ACC_W'(signed'({1'b0, qc_s3}));
		end
	end

	assign dout.valid  = v_s4;
	assign dout.x2     = x2_s4;
	assign dout.term_s = qs_s4;
	assign dout.term_c = qc_s4;
	assign dout.acc_s  = as_s4;
	assign dout.acc_c  = ac_s4;

	// quotient is exact after one correction
	a_rem_s: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && use_s |-> rs_s3 < TERM_W'(div_s)) else $error("sine remainder too big");
	a_rem_c: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> rc_s3 < TERM_W'(div_c)) else $error("cosine remainder too big");
	// stalled cell keeps its output
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dout)) else $error("cell moved while stalled");

endmodule

// File: hdl/tfp_post.sv
// ----------------------------------------------------------------------------
// tfp_post: trig rounding, rotation products and positions
// Clamps and folds the series sums by quadrant, rounds to Q1.14, forms
// the rotation entries and the saturated position, and holds the result.
// ----------------------------------------------------------------------------
module tfp_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  logic signed [tfp_pkg::ACC_W-1:0]    acc_sp,
	input  logic signed [tfp_pkg::ACC_W-1:0]    acc_cp,
	input  logic signed [tfp_pkg::ACC_W-1:0]    acc_st,
	input  logic signed [tfp_pkg::ACC_W-1:0]    acc_ct,
	input  tfp_pkg::side_t                      side,
	input  logic signed [15:0]                  base_h,
	output logic                                out_v,
	output logic signed [15:0]                  r_xx,
	output logic signed [15:0]                  r_xy,
	output logic signed [15:0]                  r_xz,
	output logic signed [15:0]                  r_yx,
	output logic signed [15:0]                  r_yy,
	output logic signed [15:0]                  r_yz,
	output logic signed [15:0]                  r_zx,
	output logic signed [15:0]                  r_zz,
	output logic signed [tfp_pkg::POS_W-1:0]    p_x,
	output logic signed [tfp_pkg::POS_W-1:0]    p_y,
	output logic signed [tfp_pkg::POS_W-1:0]    p_z
);
	import tfp_pkg::*;

	// sum limited to [0, 1.0] in Q30
	function automatic logic signed [31:0] clamp30(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v < 0)
			r = '0;
		else if (v > ACC_W'(signed'({1'b0, ONE_Q30})))
			r = 32'(ONE_Q30);
		else
			r = v[31:0];
		return r;
	endfunction

	// Q30 to trig format, half away from zero, magnitude limited
	function automatic logic signed [TRIG_W-1:0] to_trig(input logic signed [31:0] v);
		logic        neg;
		logic [31:0] m;
		logic [31:0] q;
		neg = v[31];
		m   = neg ? 32'(-v) : 32'(v);
		q   = (m + (32'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
		if (q > (32'd1 << TRIG_FRAC_BITS))
			q = 32'd1 << TRIG_FRAC_BITS;
		return neg ? -TRIG_W'(q) : TRIG_W'(q);
	endfunction

	// product shifted down by the trig fraction, half away from zero
	function automatic logic signed [LEN_W:0] mul_rnd(input logic signed [LEN_W-1:0] a,
		input logic signed [TRIG_W-1:0] b);
		logic signed [LEN_W+TRIG_W-1:0] p;
		logic        [LEN_W+TRIG_W-1:0] m;
		logic        [LEN_W+TRIG_W-1:0] q;
		p = a * b;
		m = p[LEN_W+TRIG_W-1] ? -p : p;
		q = (m + (LEN_W+TRIG_W)'(1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
		return p[LEN_W+TRIG_W-1] ? -(LEN_W+1)'(q) : (LEN_W+1)'(q);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
		logic signed [POS_W-1:0] r;
		if (v > (POS_W+1)'((1 << (POS_W - 1)) - 1))
			r = POS_W'((1 << (POS_W - 1)) - 1);
		else if (v < -(POS_W+1)'(1 << (POS_W - 1)))
			r = POS_W'(-(1 << (POS_W - 1)));
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	logic signed [31:0] s0p, c0p, s0t, c0t;
	logic signed [31:0] svp, cvp, svt, cvt;

	logic v_s1, v_s2, v_s3;
	logic signed [TRIG_W-1:0] s1_s1, c1_s1, s2_s1, c2_s1;
	logic signed [LEN_W-1:0]  len_s1, len_s2;
	logic signed [LEN_W:0]    xx_w, xz_w, yx_w, yz_w;
	logic signed [15:0] xx_s2, xy_s2, xz_s2, yx_s2, yy_s2, yz_s2, zx_s2, zz_s2;
	logic signed [15:0] xx_s3, xy_s3, xz_s3, yx_s3, yy_s3, yz_s3, zx_s3, zz_s3;
	logic signed [LEN_W:0] px_s3, py_s3, pz_s3;

	// quadrant folding
	assign s0p = clamp30(acc_sp);
	assign c0p = clamp30(acc_cp);
	assign s0t = clamp30(acc_st);
	assign c0t = clamp30(acc_ct);

	always_comb begin
		case (side.quad_p)
			2'd0:    begin svp = s0p;  cvp = c0p;  end
			2'd1:    begin svp = c0p;  cvp = -s0p; end
			2'd2:    begin svp = -s0p; cvp = -c0p; end
			default: begin svp = -c0p; cvp = s0p;  end
		endcase
		case (side.quad_t)
			2'd0:    begin svt = s0t;  cvt = c0t;  end
			2'd1:    begin svt = c0t;  cvt = -s0t; end
			2'd2:    begin svt = -s0t; cvt = -c0t; end
			default: begin svt = -c0t; cvt = s0t;  end
		endcase
	end

	// rotation products
	assign xx_w = mul_rnd(LEN_W'(c1_s1), c2_s1);
	assign xz_w = -mul_rnd(LEN_W'(s2_s1), c1_s1);
	assign yx_w = mul_rnd(LEN_W'(s1_s1), c2_s1);
	assign yz_w = -mul_rnd(LEN_W'(s1_s1), s2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			out_v <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s1  <= to_trig(svp);
			c1_s1  <= to_trig(cvp);
			s2_s1  <= to_trig(svt);
			c2_s1  <= to_trig(cvt);
			len_s1 <= side.len;

			xx_s2  <= xx_w[15:0];
			xy_s2  <= 16'(-s1_s1);
			xz_s2  <= xz_w[15:0];
			yx_s2  <= yx_w[15:0];
			yy_s2  <= 16'(c1_s1);
			yz_s2  <= yz_w[15:0];
			zx_s2  <= 16'(s2_s1);
			zz_s2  <= 16'(c2_s1);
			len_s2 <= len_s1;

			px_s3 <= mul_rnd(len_s2, xz_s2);
			py_s3 <= mul_rnd(len_s2, yz_s2);
			pz_s3 <= mul_rnd(len_s2, zz_s2);
			xx_s3 <= xx_s2;  xy_s3 <= xy_s2;  xz_s3 <= xz_s2;  yx_s3 <= yx_s2;
			yy_s3 <= yy_s2;  yz_s3 <= yz_s2;  zx_s3 <= zx_s2;  zz_s3 <= zz_s2;

			// output register
			p_x  <= sat_pos((POS_W+1)'(px_s3));
			p_y  <= sat_pos((POS_W+1)'(py_s3));
			p_z  <= sat_pos((POS_W+1)'(pz_s3) + (POS_W+1)'(base_h));
			r_xx <= xx_s3;  r_xy <= xy_s3;  r_xz <= xz_s3;  r_yx <= yx_s3;
			r_yy <= yy_s3;  r_yz <= yz_s3;  r_zx <= zx_s3;  r_zz <= zz_s3;
		end
	end

	// rounded trig never exceeds one
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (s1_s1 <= 16384 && s1_s1 >= -16384 && c2_s1 <= 16384 && c2_s1 >= -16384))
		else $error("trig value out of range");
	// pan cosine moves on to the position stage
	a_yy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en |=> yy_s3 == $past(yy_s2)) else $error("pan cosine lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(p_z) && $stable(out_v)) else $error("result moved while stalled");

endmodule

// File: hdl/turret_forward_pose.sv
// ----------------------------------------------------------------------------
// turret_forward_pose: pan / tilt / extension turret forward kinematics
// Per input beat returns the rotation entries and the saturated position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_ready carries pan_angle, tilt_angle and
//   extension. Output channel out_valid / out_ready carries rot_* and pos_*.
//   Config channel cfg_valid / cfg_ready writes link_offset (index 0) or
//   base_height (index 1) from cfg_data; other indexes are dropped. cfg_ready
//   is always high; write only while no beat is in flight.
//   One beat is taken every cycle unless the output stalls. The pipeline has
//   two front stages, a row of seven series cells of four stages each per
//   angle, and four back end stages.
//   All stages move together; when a result sits in the output register
//   and out_ready is low the whole pipeline holds and in_ready drops.
//   Reset clears all valid bits and loads link_offset 410, base_height 2048.
// ----------------------------------------------------------------------------
module turret_forward_pose (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  pan_angle,
	input  logic signed [15:0]  tilt_angle,
	input  logic signed [15:0]  extension,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  rot_xx,
	output logic signed [15:0]  rot_xy,
	output logic signed [15:0]  rot_xz,
	output logic signed [15:0]  rot_yx,
	output logic signed [15:0]  rot_yy,
	output logic signed [15:0]  rot_yz,
	output logic signed [15:0]  rot_zx,
	output logic                rot_zy,
	output logic signed [15:0]  rot_zz,
	output logic signed [18:0]  pos_x,
	output logic signed [18:0]  pos_y,
	output logic signed [18:0]  pos_z,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import tfp_pkg::*;

	localparam int R_W = ANGLE_BITS - 2;

	logic en;
	logic signed [15:0] link_q, base_q;

	logic [31:0] frac_p, frac_t;
	logic [63:0] xw_p, xw_t;
	logic [2*X_W-1:0] x2w_p, x2w_t;

	logic v_s1, v_s2;
	logic [X_W-1:0] xp_s1, xt_s1, xp_s2, xt_s2;
	logic [X2_W-1:0] x2p_s2, x2t_s2;
	side_t side_s1, side_s2;
	side_t side_q [SER_LAT];

	ser_t chain_p [CELLS+1];
	ser_t chain_t [CELLS+1];

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign rot_zy    = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= 16'sd410;
			base_q <= 16'sd2048;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINK_OFFSET: link_q <= cfg_data;
				REG_BASE_HEIGHT: base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// angle remainder to radians, then x squared
	assign frac_p = 32'(pan_angle[R_W-1:0])  << (34 - ANGLE_BITS);
	assign frac_t = 32'(tilt_angle[R_W-1:0]) << (34 - ANGLE_BITS);
	assign xw_p   = frac_p * HALF_PI_Q30;
	assign xw_t   = frac_t * HALF_PI_Q30;
	assign x2w_p  = xp_s1 * xp_s1;
	assign x2w_t  = xt_s1 * xt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s1          <= xw_p[32+X_W-1:32];
			xt_s1          <= xw_t[32+X_W-1:32];
			side_s1.quad_p <= pan_angle[ANGLE_BITS-1:R_W];
			side_s1.quad_t <= tilt_angle[ANGLE_BITS-1:R_W];
			side_s1.len    <= LEN_W'(link_q) + LEN_W'(extension);
			xp_s2          <= xp_s1;
			xt_s2          <= xt_s1;
			x2p_s2         <= x2w_p[X2_W+29:30];
			x2t_s2         <= x2w_t[X2_W+29:30];
			side_s2        <= side_s1;
		end
	end

	// side data delay beside the cells
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s2;
			for (int i = 1; i < SER_LAT; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// series seeds: sine starts at x, cosine at one
	assign chain_p[0] = '{valid: v_s2, x2: x2p_s2,
		term_s: TERM_W'(xp_s2), term_c: TERM_W'(ONE_Q30),
		acc_s: ACC_W'(signed'({1'b0, xp_s2})), acc_c: ACC_W'(signed'({1'b0, ONE_Q30}))};
	assign chain_t[0] = '{valid: v_s2, x2: x2t_s2,
		term_s: TERM_W'(xt_s2), term_c: TERM_W'(ONE_Q30),
		acc_s: ACC_W'(signed'({1'b0, xt_s2})), acc_c: ACC_W'(signed'({1'b0, ONE_Q30}))};

	// row of series cells per angle
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		tfp_cell u_cell_p (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain_p[k]),
			.div_s  (DIV_S[k]),
			.rcp_s  (RCP_S[k]),
			.div_c  (DIV_C[k]),
			.rcp_c  (RCP_C[k]),
			.use_s  (SIN_USE[k]),
			.sub    ((k % 2) == 0),
			.dout   (chain_p[k+1])
		);
		tfp_cell u_cell_t (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain_t[k]),
			.div_s  (DIV_S[k]),
			.rcp_s  (RCP_S[k]),
			.div_c  (DIV_C[k]),
			.rcp_c  (RCP_C[k]),
			.use_s  (SIN_USE[k]),
			.sub    ((k % 2) == 0),
			.dout   (chain_t[k+1])
		);
	end

	tfp_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (chain_p[CELLS].valid && chain_t[CELLS].valid),
		.acc_sp (chain_p[CELLS].acc_s),
		.acc_cp (chain_p[CELLS].acc_c),
		.acc_st (chain_t[CELLS].acc_s),
		.acc_ct (chain_t[CELLS].acc_c),
		.side   (side_q[SER_LAT-1]),
		.base_h (base_q),
		.out_v  (out_valid),
		.r_xx   (rot_xx),
		.r_xy   (rot_xy),
		.r_xz   (rot_xz),
		.r_yx   (rot_yx),
		.r_yy   (rot_yy),
		.r_yz   (rot_yz),
		.r_zx   (rot_zx),
		.r_zz   (rot_zz),
		.p_x    (pos_x),
		.p_y    (pos_y),
		.p_z    (pos_z)
	);

	// both angle rows stay in step
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		chain_p[CELLS].valid == chain_t[CELLS].valid) else $error("angle rows out of step");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1) else $error("accepted beat lost");

endmodule
